/* rtl/rtpfp_pkg.sv */
// ----------------------------------------------------------------------------
// rtpfp_pkg
// Shared types and constants of the RTP frame packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpfp_pkg;

    localparam int DIV_BITS   = 24;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS + 1);
    localparam int PROD_W     = 49;

    localparam logic [1:0]  CFG_FRAME_RATE = 2'd0;
    localparam logic [1:0]  CFG_IS_AUDIO   = 2'd1;
    localparam logic [1:0]  CFG_SOURCE_ID  = 2'd2;

    localparam logic        KIND_TICK      = 1'b0;
    localparam logic        KIND_BITRATE   = 1'b1;

    localparam logic [7:0]  RTP_V2         = 8'h80;
    localparam logic [6:0]  PT_VIDEO       = 7'd96;
    localparam logic [16:0] VIDEO_CLOCK    = 17'd90000;
    localparam logic [10:0] HDR_BYTES      = 11'd12;
    localparam logic [26:0] BITRATE_RESET  = 27'd1000000;
    localparam logic [7:0]  FPS_RESET      = 8'd50;

    typedef struct packed {
        logic        kind;
        logic [31:0] ntp_time;
        logic [26:0] new_bitrate;
    } t_in;

    typedef struct packed {
        logic [31:0] header_first_word;
        logic [31:0] rtp_timestamp;
        logic [31:0] header_source_id;
        logic [10:0] payload_length;
        logic [10:0] packet_length;
        logic        last;
    } t_out;

    typedef struct packed {
        logic load_bitrate;
        logic start_frame;
        logic div_step;
        logic size_load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_bitrate;
        logic div_done;
        logic rem_zero;
        logic rem_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/rtp_frame_packetizer.sv */
// ----------------------------------------------------------------------------
// rtp_frame_packetizer
// RTP header generator for a constant-bitrate frame source.
// ----------------------------------------------------------------------------
// A bitrate update item is taken and produces nothing. A frame tick item
// passes through an accept step, the one-bit-per-cycle restoring divider
// that forms bitrate / (8 * fps), a sizing step, then one header per cycle
// into the output register while the sink keeps up, one for each of its 1 to
// MAX_PACKETS packets (an empty frame returns to idle with nothing to send).
// The timestamp product is formed once, on acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_frame_packetizer #(
    parameter int MAX_PACKETS = 64,
    parameter int MAX_PAYLOAD = 1396
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rtpfp_pkg::t_in  i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output rtpfp_pkg::t_out      o_out
);

    rtpfp_pkg::t_cmd w_cmd;
    rtpfp_pkg::t_sts w_sts;

    rtpfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rtpfp_dp #(
        .MAX_PACKETS (MAX_PACKETS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* rtl/rtpfp_ctrl.sv */
// ----------------------------------------------------------------------------
// rtpfp_ctrl
// Sequencer: accepts items, runs the frame-size divide, then emits packets.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpfp_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rtpfp_pkg::t_sts i_sts,
    output rtpfp_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_sts.is_bitrate) begin
                        o_cmd.load_bitrate = 1'b1;
                    end else begin
                        o_cmd.start_frame = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.size_load = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.rem_zero) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.rem_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/rtpfp_dp.sv */
// ----------------------------------------------------------------------------
// rtpfp_dp
// Datapath: config registers, bit-serial divider, timestamp multiplier,
// packet splitter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpfp_dp #(
    parameter int MAX_PACKETS = 64,
    parameter int MAX_PAYLOAD = 1396
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire rtpfp_pkg::t_in  i_in,
    input  wire rtpfp_pkg::t_cmd i_cmd,
    output rtpfp_pkg::t_sts      o_sts,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output rtpfp_pkg::t_out      o_out
);

    localparam int LIMIT = MAX_PACKETS * MAX_PAYLOAD;
    localparam int REM_W = $clog2(LIMIT + 1);
    localparam int DB    = rtpfp_pkg::DIV_BITS;

    logic [7:0]                      r_frame_rate;
    logic                            r_is_audio;
    logic [31:0]                     r_source_id;
    logic [26:0]                     r_bitrate;
    logic [15:0]                     r_seq;
    logic [rtpfp_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [DB-1:0]                   r_quo;
    logic [7:0]                      r_prt;
    logic [7:0]                      r_divisor;
    logic [rtpfp_pkg::PROD_W-1:0]    r_prod;
    logic [REM_W-1:0]                r_rem;
    logic                            r_out_valid;
    rtpfp_pkg::t_out                 r_out;

    logic [8:0]       w_trial;
    logic [8:0]       w_diff;
    logic [REM_W-1:0] w_sat;
    logic [REM_W-1:0] w_pay;
    logic             w_last;
    logic [6:0]       w_pt;

    assign w_trial = {r_prt, r_quo[DB-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_sat   = (r_quo > DB'(LIMIT)) ? REM_W'(LIMIT) : REM_W'(r_quo);
    assign w_last  = (r_rem <= REM_W'(MAX_PAYLOAD));
    assign w_pay   = w_last ? r_rem : REM_W'(MAX_PAYLOAD);
    assign w_pt    = rtpfp_pkg::PT_VIDEO + 7'(r_is_audio);

    assign o_sts.is_bitrate = (i_in.kind == rtpfp_pkg::KIND_BITRATE);
    assign o_sts.div_done   = (r_div_cnt == '0);
    assign o_sts.rem_zero   = (r_rem == '0);
    assign o_sts.rem_last   = w_last;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= rtpfp_pkg::FPS_RESET;
            r_is_audio   <= 1'b0;
            r_source_id  <= '0;
            r_bitrate    <= rtpfp_pkg::BITRATE_RESET;
            r_seq        <= '0;
            r_div_cnt    <= '0;
            r_rem        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtpfp_pkg::CFG_FRAME_RATE: r_frame_rate <= i_cfg_data[7:0];
                    rtpfp_pkg::CFG_IS_AUDIO:   r_is_audio   <= i_cfg_data[0];
                    rtpfp_pkg::CFG_SOURCE_ID:  r_source_id  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_bitrate) begin
                r_bitrate <= i_in.new_bitrate;
            end
            if (i_cmd.start_frame) begin
                r_div_cnt <= rtpfp_pkg::DIV_CNT_W'(DB);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (i_cmd.size_load) begin
                r_rem <= w_sat;
            end else if (i_cmd.emit) begin
                r_rem <= r_rem - w_pay;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_seq       <= r_seq + 16'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider and multiplier operands, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_frame) begin
            r_quo     <= r_bitrate[26:3];
            r_prt     <= '0;
            r_divisor <= (r_frame_rate == '0) ? 8'd1 : r_frame_rate;
            r_prod    <= rtpfp_pkg::PROD_W'(i_in.ntp_time)
                         * rtpfp_pkg::PROD_W'(rtpfp_pkg::VIDEO_CLOCK);
        end else if (i_cmd.div_step) begin
            if (!w_diff[8]) begin
                r_prt <= w_diff[7:0];
                r_quo <= {r_quo[DB-2:0], 1'b1};
            end else begin
                r_prt <= w_trial[7:0];
                r_quo <= {r_quo[DB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.header_first_word <= {rtpfp_pkg::RTP_V2, w_last, w_pt, r_seq};
            r_out.rtp_timestamp     <= r_prod[47:16];
            r_out.header_source_id  <= r_source_id;
            r_out.payload_length    <= 11'(w_pay);
            r_out.packet_length     <= 11'(w_pay) + rtpfp_pkg::HDR_BYTES;
            r_out.last              <= w_last;
        end
    end

endmodule

`default_nettype wire

/* rtl/rtpfp_checker.sv */
// ----------------------------------------------------------------------------
// rtpfp_checker
// Port-level checks of the packetizer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpfp_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire rtpfp_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output item changed while stalled");

    a_pkt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out.packet_length == o_out.payload_length + rtpfp_pkg::HDR_BYTES
            && o_out.payload_length != '0)
        else $error("packet length inconsistent with payload length");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.last == o_out.header_first_word[23])
        else $error("marker bit differs from last flag");

    a_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.header_first_word[31:24] == rtpfp_pkg::RTP_V2
            && o_out.header_first_word[22:17] == rtpfp_pkg::PT_VIDEO[6:1])
        else $error("bad RTP version or payload type");

endmodule

bind rtp_frame_packetizer rtpfp_checker u_rtpfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
